// ----- design/tpa_pkg.sv -----
package tpa_pkg;

    localparam int TAG_WIDTH = 16;
    localparam int SLOT_COUNT = 3;

    typedef logic [TAG_WIDTH-1:0] tag_t;
    typedef logic [1:0]           slot_idx_t;
    typedef logic [2:0]           vcount_t;
    typedef logic [2:0]           prim_mode_t;

    localparam prim_mode_t MODE_TRIANGLES = 3'd0;
    localparam prim_mode_t MODE_STRIP     = 3'd1;
    localparam prim_mode_t MODE_FAN       = 3'd2;
    localparam prim_mode_t MODE_QUADS     = 3'd3;

    typedef struct packed {
        logic begin_req;
        tag_t vertex_tag;
    } vertex_beat_t;

    typedef struct packed {
        tag_t tri_first;
        tag_t tri_second;
        tag_t tri_third;
    } triangle_t;

    typedef struct packed {
        logic      emit;
        triangle_t tri_tags;
    } asm_result_t;

endpackage

// ----- design/triangle_primitive_assembler_top.sv -----
// Triangle primitive assembler. Takes one vertex beat per cycle while in_stall
// is low and emits at most one triangle (three vertex tags) per vertex. A
// vertex is registered on input, assembled against the three vertex slots
// once no output beat is held by out_stall, and its triangle lands in the
// output register; one vertex per cycle is sustained while out_stall is low.
// in_stall rises only while a vertex waits in the input register behind an
// output beat held by out_stall. prim_mode selects triangles, strip, fan or
// quads; other codes store vertices and emit nothing. Write prim_mode only
// when the block is empty. A vertex with begin_req set restarts the primitive.
module triangle_primitive_assembler_top
    import tpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  prim_mode_t   cfg_wr_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  vertex_beat_t in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output triangle_t    out_data
);

    prim_mode_t   mode_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    vertex_beat_t in_beat_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    triangle_t    out_data_reg;
    logic         out_blocked;
    logic         advance;
    logic         accept;
    asm_result_t  asm_res;

    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = in_valid_reg && !out_blocked;
    assign in_stall    = in_valid_reg && out_blocked;
    assign accept      = in_valid && !in_stall;

    tpa_assembler u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .beat      (in_beat_reg),
        .prim_mode (mode_reg),
        .result    (asm_res)
    );

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = asm_res.emit;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TRIANGLES;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_beat_reg <= in_data;
        if (advance && asm_res.emit)
            out_data_reg <= asm_res.tri_tags;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/tpa_assembler.sv -----
module tpa_assembler
    import tpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  vertex_beat_t beat,
    input  prim_mode_t   prim_mode,
    output asm_result_t  result
);

    tag_t      slots_reg [SLOT_COUNT];
    slot_idx_t order_reg [SLOT_COUNT];
    slot_idx_t order_next [SLOT_COUNT];
    slot_idx_t order_cur [SLOT_COUNT];
    slot_idx_t wslot_reg;
    slot_idx_t wslot_next;
    slot_idx_t wslot_cur;
    vcount_t   count_reg;
    vcount_t   count_next;
    vcount_t   count_cur;
    vcount_t   count_bumped;
    tag_t      slot_view [SLOT_COUNT];

    function automatic tag_t pick_slot(input tag_t v0, input tag_t v1, input tag_t v2,
                                       input slot_idx_t idx);
        tag_t t;
        unique case (idx)
            2'd1:    t = v1;
            2'd2:    t = v2;
            default: t = v0;
        endcase
        return t;
    endfunction

    // (c + 1) mod 3 for c in 2..7
    function automatic slot_idx_t next_mod3(input vcount_t c);
        slot_idx_t r;
        unique case (c)
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd0;
            3'd6:    r = 2'd1;
            3'd7:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        // a begin beat restarts the primitive before this vertex is stored
        if (beat.begin_req)
        begin
            order_cur[0] = 2'd0;
            order_cur[1] = 2'd1;
            order_cur[2] = 2'd2;
            wslot_cur    = '0;
            count_cur    = '0;
        end
        else
        begin
            order_cur = order_reg;
            wslot_cur = wslot_reg;
            count_cur = count_reg;
        end

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_view[i] = (wslot_cur == slot_idx_t'(i)) ? beat.vertex_tag : slots_reg[i];
        end

        result.tri_tags.tri_first  =
            pick_slot(slot_view[0], slot_view[1], slot_view[2], order_cur[0]);
        result.tri_tags.tri_second =
            pick_slot(slot_view[0], slot_view[1], slot_view[2], order_cur[1]);
        result.tri_tags.tri_third  =
            pick_slot(slot_view[0], slot_view[1], slot_view[2], order_cur[2]);

        // strip/fan counter wraps 7 -> 2
        count_bumped = (count_cur == 3'd7) ? 3'd2 : count_cur + 3'd1;

        order_next  = order_cur;
        wslot_next  = wslot_cur;
        count_next  = count_cur;
        result.emit = 1'b0;

        if (prim_mode > MODE_QUADS)
        begin
            // lines and points: vertex stored, nothing assembled
        end
        else if (count_cur < 3'd2)
        begin
            count_next = count_cur + 3'd1;
            wslot_next = count_cur[0] ? order_cur[2] : order_cur[1];
        end
        else
        begin
            result.emit = 1'b1;
            unique case (prim_mode)
                MODE_TRIANGLES:
                begin
                    count_next = '0;
                    wslot_next = order_cur[0];
                end
                MODE_STRIP:
                begin
                    count_next = count_bumped;
                    if (count_bumped[0])
                        order_next[1] = order_cur[0];
                    else
                        order_next[2] = order_cur[0];
                    wslot_next    = order_cur[0];
                    order_next[0] = next_mod3(count_bumped);
                end
                MODE_FAN:
                begin
                    count_next    = count_bumped;
                    order_next[1] = order_cur[2];
                    order_next[2] = count_bumped[0] ? 2'd1 : 2'd2;
                    wslot_next    = count_bumped[0] ? 2'd1 : 2'd2;
                end
                default:
                begin
                    // quads: second half reuses a and c
                    count_next    = {1'b0, count_cur[1:0] + 2'd1};
                    wslot_next    = {1'b0, ~count_cur[0]};
                    order_next[1] = order_cur[2];
                    order_next[2] = order_cur[1];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg[0] <= 2'd0;
            order_reg[1] <= 2'd1;
            order_reg[2] <= 2'd2;
            wslot_reg    <= '0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            order_reg <= order_next;
            wslot_reg <= wslot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (step && wslot_cur == slot_idx_t'(i))
                slots_reg[i] <= beat.vertex_tag;
        end
    end

endmodule

// ----- design/tpa_checker.sv -----
module tpa_checker
    import tpa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input triangle_t out_data
);

    // held output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // input backpressure only comes from a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without blocked output");

    // a fresh triangle needs an earlier accepted vertex
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("triangle without a preceding vertex");

    // output beats leave only when taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("output beat dropped");

endmodule

bind triangle_primitive_assembler_top tpa_checker u_tpa_checker (.*);

// ----- bench/tb_triangle_primitive_assembler_top.sv -----
`timescale 1ns / 100ps

module tb_triangle_primitive_assembler_top;
    import tpa_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_MODE = 80;
    localparam int MAX_REPORTS    = 10;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    prim_mode_t   cfg_wr_data = MODE_TRIANGLES;
    logic         in_valid = 1'b0;
    logic         in_stall;
    vertex_beat_t in_data = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    triangle_t    out_data;

    // assembler shadow state
    tag_t       slot_tag [3] = '{default: '0};
    slot_idx_t  order [3] = '{2'd0, 2'd1, 2'd2};
    slot_idx_t  wr_slot = '0;
    vcount_t    vcount = '0;
    prim_mode_t mode_now = MODE_TRIANGLES;

    triangle_t  tri_queue [$];
    int         err_count = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_req = 1'b0;

    triangle_primitive_assembler_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit assemble_vertex(input vertex_beat_t v, output triangle_t tri_out);
        slot_idx_t held;
        tri_out = '0;
        if (v.begin_req)
        begin
            vcount   = '0;
            order[0] = 2'd0;
            order[1] = 2'd1;
            order[2] = 2'd2;
            wr_slot  = 2'd0;
        end
        slot_tag[wr_slot] = v.vertex_tag;
        if (mode_now > MODE_QUADS)
            return 1'b0;
        if (vcount < 3'd2)
        begin
            vcount  = vcount + 3'd1;
            wr_slot = order[vcount[1:0]];
            return 1'b0;
        end
        tri_out.tri_first  = slot_tag[order[0]];
        tri_out.tri_second = slot_tag[order[1]];
        tri_out.tri_third  = slot_tag[order[2]];
        case (mode_now)
            MODE_TRIANGLES:
            begin
                vcount  = '0;
                wr_slot = order[0];
            end
            MODE_STRIP:
            begin
                // counter cycles 2..7
                vcount = (vcount == 3'd7) ? 3'd2 : vcount + 3'd1;
                order[2 - vcount[0]] = order[0];
                wr_slot  = order[0];
                order[0] = slot_idx_t'((int'(vcount) + 1) % 3);
            end
            MODE_FAN:
            begin
                vcount   = (vcount == 3'd7) ? 3'd2 : vcount + 3'd1;
                order[1] = order[2];
                order[2] = slot_idx_t'(2 - vcount[0]);
                wr_slot  = order[2];
            end
            default:
            begin
                // quads: (a,b,c) then (a,c,d)
                vcount   = {1'b0, vcount[1:0] + 2'd1};
                wr_slot  = {1'b0, vcount[0]};
                held     = order[1];
                order[1] = order[2];
                order[2] = held;
            end
        endcase
        return 1'b1;
    endfunction

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        triangle_t got;
        triangle_t want;
        triangle_t made;
        bit        any_beat;
        if (rst_n)
        begin
            any_beat = 1'b0;
            if (out_valid && !out_stall)
            begin
                any_beat = 1'b1;
                got = out_data;
                if (tri_queue.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected triangle %h %h %h",
                                 got.tri_first, got.tri_second, got.tri_third);
                end
                else
                begin
                    want = tri_queue.pop_front();
                    if (got.tri_first !== want.tri_first ||
                        got.tri_second !== want.tri_second ||
                        got.tri_third !== want.tri_third)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("triangle mismatch: expected %h %h %h, got %h %h %h",
                                     want.tri_first, want.tri_second, want.tri_third,
                                     got.tri_first, got.tri_second, got.tri_third);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                any_beat = 1'b1;
                if (assemble_vertex(in_data, made))
                    tri_queue.push_back(made);
            end
            quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random stall, or one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_vertex(input logic first, input tag_t tag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{begin_req: first, vertex_tag: tag};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tri_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input prim_mode_t m);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_now = m;
    endtask

    // mostly begin-led primitives of random length, some loose beats
    task automatic send_sequences(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++)
                    send_vertex(i == 0, tag_t'($urandom_range(0, 65535)));
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_vertex(1'($urandom_range(0, 1)), tag_t'($urandom_range(0, 65535)));
            end
            sent += len;
        end
    endtask

    // no begin on mode change, so streams carry across settings
    task automatic run_random_settings(input int send_pct, input int recv_pct);
        prim_mode_t m;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < 4; s++)
        begin
            if ($urandom_range(0, 9) < 8)
                m = prim_mode_t'($urandom_range(0, 3));
            else
                m = prim_mode_t'($urandom_range(4, 7));
            write_mode(m);
            send_sequences((m > MODE_QUADS) ? 10 : ITEMS_PER_MODE);
        end
    endtask

    task automatic test_directed();
        write_mode(MODE_TRIANGLES);
        send_vertex(1'b1, 16'h0000);
        send_vertex(1'b0, 16'hFFFF);
        send_vertex(1'b0, 16'h5A5A);
        // strip long enough to wrap the counter
        write_mode(MODE_STRIP);
        for (int i = 0; i < 9; i++)
            send_vertex(i == 0, tag_t'(16'h1100 + i));
        write_mode(MODE_FAN);
        for (int i = 0; i < 5; i++)
            send_vertex(i == 0, tag_t'(16'h2200 + i));
        write_mode(MODE_QUADS);
        for (int i = 0; i < 4; i++)
            send_vertex(i == 0, tag_t'(16'h3300 + i));
        // lines/points and unused codes store only
        write_mode(prim_mode_t'(4));
        send_vertex(1'b1, 16'hFFFF);
        send_vertex(1'b0, 16'h0000);
        write_mode(prim_mode_t'(7));
        send_vertex(1'b0, 16'hA5A5);
    endtask

    task automatic test_no_idle();
        run_random_settings(0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_settings(62, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_settings(0, 62);
    endtask

    task automatic test_both_idle();
        run_random_settings(29, 29);
    endtask

    // fill the pipe behind a long output hold, input must back up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_mode(MODE_STRIP);
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++)
            send_vertex(i == 0, tag_t'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        wait_idle();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
